@@ design/rotate_point_about_origin_defines.svh @@
// Assertion macros shared by the rotate point checker.
`ifndef ROTATE_POINT_ABOUT_ORIGIN_DEFINES_SVH
`define ROTATE_POINT_ABOUT_ORIGIN_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RPAO_ASSERT_IMP(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("rpao: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define RPAO_ASSERT_NXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("rpao: next-cycle check failed");

`endif

@@ design/rpao_pkg.sv @@
// Shared constants, payload types and elaboration-time tables for the point rotator.
package rpao_pkg;

    localparam int FRAC_BITS_DEF    = 16;
    localparam int CORDIC_STEPS_DEF = 18;

    localparam int CW    = 32;            // coordinate width
    localparam int DW    = CW + 1;        // point minus origin, never wraps
    localparam int GUARD = 16;            // extra fraction bits in the rotator
    localparam int KFRAC = 31;            // gain fraction bits
    localparam int XW    = DW + GUARD + 3;
    localparam int ZW    = 44;            // residual angle, radians in Q40

    localparam int DEG_FULL    = 360;
    localparam int DEG_HALF    = 180;
    localparam int DEG_QUARTER = 90;

    localparam logic [31:0] PI180_Q37      = 32'd2398762259;
    localparam logic [63:0] QUARTER_PI_Q40 = 64'd863554413089;

    typedef struct packed {
        logic signed [DW-1:0] dx;
        logic signed [DW-1:0] dy;
        logic signed [CW-1:0] ox;
        logic signed [CW-1:0] oy;
        logic signed [ZW-1:0] z;
        logic                 flip;
    } rpao_angle_t;

    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
        logic signed [CW-1:0] ox;
        logic signed [CW-1:0] oy;
    } rpao_rot_t;

    // Unsigned restoring division, used only to build constant tables.
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int j = 63; j >= 0; j--)
        begin
            rem = {rem[63:0], num[j]};
            if (rem >= {1'b0, den})
            begin
                rem    = rem - {1'b0, den};
                quo[j] = 1'b1;
            end
        end
        return quo;
    endfunction

    // atan(2^-step) in Q40: power series in Q62, terms truncated, then rounded.
    function automatic logic signed [ZW-1:0] atan_q40(input int step);
        logic signed [63:0] sum;
        logic signed [63:0] term;
        logic               neg;
        logic signed [ZW-1:0] res;
        sum = '0;
        neg = 1'b0;
        if (step == 0) begin
            res = ZW'(QUARTER_PI_Q40);
        end
        else begin
            for (int k = 1; k * step < 62; k += 2) begin
                term = udiv64(64'd1 << (62 - k * step), 64'(k));
                sum  = neg ? (sum - term) : (sum + term);
                neg  = ~neg;
            end
            res = ZW'((sum + (64'sd1 <<< 21)) >>> 22);
        end
        return res;
    endfunction

    function automatic logic [63:0] isqrt64(input logic [63:0] n);
        logic [63:0] rem;
        logic [63:0] res;
        logic [63:0] b;
        rem = n;
        res = '0;
        b   = 64'd1 << 62;
        for (int j = 0; j < 32; j++) begin
            if (b > rem) begin
                b = b >> 2;
            end
        end
        for (int j = 0; j < 32; j++) begin
            if (b != 64'd0) begin
                if (rem >= res + b) begin
                    rem = rem - (res + b);
                    res = (res >> 1) + b;
                end
                else begin
                    res = res >> 1;
                end
                b = b >> 2;
            end
        end
        return res;
    endfunction

    // Inverse CORDIC gain in Q31 for the given number of iterations.
    function automatic logic [KFRAC-1:0] gain_q31(input int steps);
        logic [63:0] k2;
        k2 = 64'd1 << 62;
        for (int i = 0; i < steps; i++) begin
            k2 = k2 - udiv64(k2, (64'd1 << (2 * i)) + 64'd1);
        end
        return KFRAC'(isqrt64(k2));
    endfunction

endpackage

@@ design/rpao_if.sv @@
// Valid/ready channel interfaces for input points and rotated results.
interface rpao_in_if;
    logic                            valid;
    logic                            ready;
    logic signed [rpao_pkg::CW-1:0]  point_x;
    logic signed [rpao_pkg::CW-1:0]  point_y;
    logic signed [rpao_pkg::CW-1:0]  origin_x;
    logic signed [rpao_pkg::CW-1:0]  origin_y;
    logic signed [rpao_pkg::CW-1:0]  angle_deg;

    modport source (
        output valid, point_x, point_y, origin_x, origin_y, angle_deg,
        input  ready
    );
    modport sink (
        input  valid, point_x, point_y, origin_x, origin_y, angle_deg,
        output ready
    );
endinterface

interface rpao_out_if;
    logic                            valid;
    logic                            ready;
    logic signed [rpao_pkg::CW-1:0]  rotated_x;
    logic signed [rpao_pkg::CW-1:0]  rotated_y;
    logic                            saturated;

    modport source (
        output valid, rotated_x, rotated_y, saturated,
        input  ready
    );
    modport sink (
        input  valid, rotated_x, rotated_y, saturated,
        output ready
    );
endinterface

@@ design/rpao_angle.sv @@
// Angle reduction modulo 360 degrees, quadrant fold and conversion to radians.
module rpao_angle #(
    parameter int FRAC_BITS = rpao_pkg::FRAC_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    rpao_in_if.sink               point,
    output logic                  out_valid,
    input  logic                  out_ready,
    output rpao_pkg::rpao_angle_t out_data
);

    localparam int NST = 7;
    localparam int FW  = FRAC_BITS + 9;    // holds one full turn
    localparam int MW  = 25 - FRAC_BITS;   // quotient width
    localparam int AW  = FW + 2;           // signed remainder width
    localparam int RW  = FRAC_BITS + 8;    // folded angle, signed
    localparam int PW  = RW + 33;          // degrees times pi/180

    localparam logic [63:0] FULL    = 64'(rpao_pkg::DEG_FULL) << FRAC_BITS;
    localparam logic [63:0] HALF    = 64'(rpao_pkg::DEG_HALF) << FRAC_BITS;
    localparam logic [63:0] QUARTER = 64'(rpao_pkg::DEG_QUARTER) << FRAC_BITS;
    localparam logic [63:0] THREEQ  = FULL - QUARTER;
    localparam logic [63:0] RECIP   = (64'd1 << 32) / FULL;
    localparam logic [63:0] OFFS    = (64'd1 << 31) % FULL;
    localparam logic [63:0] BACK    = FULL - OFFS;
    localparam logic signed [PW-1:0] ZRND = PW'(1) <<< (FRAC_BITS - 4);

    logic [NST-1:0] vld_reg;
    logic [NST-1:0] vld_next;
    logic [NST-1:0] vld_src;
    logic [NST:0]   adv;

    always_comb
    begin
        adv[NST] = out_ready;
        for (int s = NST - 1; s >= 0; s--)
        begin
            adv[s] = !vld_reg[s] || adv[s+1];
        end
    end

    assign vld_src  = {vld_reg[NST-2:0], point.valid};
    assign vld_next = (vld_src & adv[NST-1:0]) | (vld_reg & ~adv[NST-1:0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign point.ready = adv[0];
    assign out_valid   = vld_reg[NST-1];

    // stage 1: offset angle to unsigned, estimate quotient, form differences
    logic [31:0]            u1_next;
    logic [32+MW-1:0]       prod1;
    rpao_pkg::rpao_angle_t  g1_next;
    logic [31:0]            u1_reg;
    logic [MW-1:0]          q1_reg;
    rpao_pkg::rpao_angle_t  g1_reg;

    assign u1_next = {~point.angle_deg[31], point.angle_deg[30:0]};
    assign prod1   = u1_next * RECIP[MW-1:0];

    always_comb
    begin
        g1_next      = '0;
        g1_next.dx   = rpao_pkg::DW'(point.point_x) - rpao_pkg::DW'(point.origin_x);
        g1_next.dy   = rpao_pkg::DW'(point.point_y) - rpao_pkg::DW'(point.origin_y);
        g1_next.ox   = point.origin_x;
        g1_next.oy   = point.origin_y;
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            u1_reg <= u1_next;
            q1_reg <= prod1[32 +: MW];
            g1_reg <= g1_next;
        end
    end

    // stage 2: quotient times one turn
    logic [MW+FW-1:0]       qf_full;
    logic [31:0]            u2_reg;
    logic [31:0]            qf2_reg;
    rpao_pkg::rpao_angle_t  g2_reg;

    assign qf_full = q1_reg * FULL[FW-1:0];

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            u2_reg  <= u1_reg;
            qf2_reg <= qf_full[31:0];
            g2_reg  <= g1_reg;
        end
    end

    // stage 3: remainder, one correction step for the low quotient estimate
    logic [AW-1:0]          rem3;
    logic [AW-1:0]          remf3;
    logic [FW-1:0]          r3_next;
    logic [FW-1:0]          r3_reg;
    rpao_pkg::rpao_angle_t  g3_reg;

    assign rem3    = AW'(u2_reg) - AW'(qf2_reg);
    assign remf3   = rem3 - FULL[AW-1:0];
    assign r3_next = remf3[AW-1] ? rem3[FW-1:0] : remf3[FW-1:0];

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            r3_reg <= r3_next;
            g3_reg <= g2_reg;
        end
    end

    // stage 4: remove the unsigned offset, wrap back into one turn
    logic [AW-1:0]          s4;
    logic [AW-1:0]          t4;
    logic [FW-1:0]          r4_next;
    logic [FW-1:0]          r4_reg;
    rpao_pkg::rpao_angle_t  g4_reg;

    assign s4      = AW'(r3_reg) - OFFS[AW-1:0];
    assign t4      = AW'(r3_reg) + BACK[AW-1:0];
    assign r4_next = s4[AW-1] ? t4[FW-1:0] : s4[FW-1:0];

    always_ff @(posedge clk)
    begin
        if (adv[3])
        begin
            r4_reg <= r4_next;
            g4_reg <= g3_reg;
        end
    end

    // stage 5: fold into [-90, 90]; the middle half turn negates the vector
    logic [AW-1:0]          rza5;
    logic [AW-1:0]          rzb5;
    logic signed [RW-1:0]   rz5_next;
    logic                   flip5;
    rpao_pkg::rpao_angle_t  g5_next;
    logic signed [RW-1:0]   rz5_reg;
    rpao_pkg::rpao_angle_t  g5_reg;

    assign rza5 = AW'(r4_reg) - HALF[AW-1:0];
    assign rzb5 = AW'(r4_reg) - FULL[AW-1:0];

    always_comb
    begin
        if (r4_reg <= QUARTER[FW-1:0])
        begin
            rz5_next = $signed(r4_reg[RW-1:0]);
            flip5    = 1'b0;
        end
        else if (r4_reg < THREEQ[FW-1:0])
        begin
            rz5_next = $signed(rza5[RW-1:0]);
            flip5    = 1'b1;
        end
        else
        begin
            rz5_next = $signed(rzb5[RW-1:0]);
            flip5    = 1'b0;
        end
        g5_next      = g4_reg;
        g5_next.flip = flip5;
    end

    always_ff @(posedge clk)
    begin
        if (adv[4])
        begin
            rz5_reg <= rz5_next;
            g5_reg  <= g5_next;
        end
    end

    // stage 6: degrees times pi/180
    logic signed [PW-1:0]   zp6_next;
    logic signed [PW-1:0]   zp6_reg;
    rpao_pkg::rpao_angle_t  g6_reg;

    assign zp6_next = rz5_reg * $signed({1'b0, rpao_pkg::PI180_Q37});

    always_ff @(posedge clk)
    begin
        if (adv[5])
        begin
            zp6_reg <= zp6_next;
            g6_reg  <= g5_reg;
        end
    end

    // stage 7: round half up into Q40
    logic signed [PW-1:0]   zr7;
    logic signed [PW-1:0]   zs7;
    rpao_pkg::rpao_angle_t  g7_next;
    rpao_pkg::rpao_angle_t  g7_reg;

    assign zr7 = zp6_reg + ZRND;
    assign zs7 = zr7 >>> (FRAC_BITS - 3);

    always_comb
    begin
        g7_next   = g6_reg;
        g7_next.z = zs7[rpao_pkg::ZW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv[6])
        begin
            g7_reg <= g7_next;
        end
    end

    assign out_data = g7_reg;

endmodule

@@ design/rpao_prescale.sv @@
// Gain compensation of the difference vector and half-turn negation.
module rpao_prescale #(
    parameter int CORDIC_STEPS = rpao_pkg::CORDIC_STEPS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  rpao_pkg::rpao_angle_t in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output rpao_pkg::rpao_rot_t   out_data
);

    localparam int NST = 3;
    localparam int MPW = rpao_pkg::DW + rpao_pkg::KFRAC + 1;
    localparam int SH  = rpao_pkg::KFRAC - rpao_pkg::GUARD;
    localparam logic [rpao_pkg::KFRAC-1:0] GAIN = rpao_pkg::gain_q31(CORDIC_STEPS);
    localparam logic signed [MPW-1:0] PRND = MPW'(1) <<< (SH - 1);

    typedef struct packed {
        logic signed [rpao_pkg::CW-1:0] ox;
        logic signed [rpao_pkg::CW-1:0] oy;
        logic signed [rpao_pkg::ZW-1:0] z;
        logic                           flip;
    } side_t;

    logic [NST-1:0] vld_reg;
    logic [NST-1:0] vld_next;
    logic [NST-1:0] vld_src;
    logic [NST:0]   adv;

    always_comb
    begin
        adv[NST] = out_ready;
        for (int s = NST - 1; s >= 0; s--)
        begin
            adv[s] = !vld_reg[s] || adv[s+1];
        end
    end

    assign vld_src  = {vld_reg[NST-2:0], in_valid};
    assign vld_next = (vld_src & adv[NST-1:0]) | (vld_reg & ~adv[NST-1:0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign in_ready  = adv[0];
    assign out_valid = vld_reg[NST-1];

    // stage 1: multiply by the inverse gain
    logic signed [MPW-1:0] mx1_next;
    logic signed [MPW-1:0] my1_next;
    logic signed [MPW-1:0] mx1_reg;
    logic signed [MPW-1:0] my1_reg;
    side_t                 sd1_next;
    side_t                 sd1_reg;

    assign mx1_next = in_data.dx * $signed({1'b0, GAIN});
    assign my1_next = in_data.dy * $signed({1'b0, GAIN});
    assign sd1_next = '{ox: in_data.ox, oy: in_data.oy, z: in_data.z, flip: in_data.flip};

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            mx1_reg <= mx1_next;
            my1_reg <= my1_next;
            sd1_reg <= sd1_next;
        end
    end

    // stage 2: round half up, keep the guard bits
    logic signed [MPW-1:0]          mxr2;
    logic signed [MPW-1:0]          myr2;
    logic signed [rpao_pkg::XW-1:0] x2_reg;
    logic signed [rpao_pkg::XW-1:0] y2_reg;
    side_t                          sd2_reg;

    assign mxr2 = (mx1_reg + PRND) >>> SH;
    assign myr2 = (my1_reg + PRND) >>> SH;

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            x2_reg  <= mxr2[rpao_pkg::XW-1:0];
            y2_reg  <= myr2[rpao_pkg::XW-1:0];
            sd2_reg <= sd1_reg;
        end
    end

    // stage 3: negate for the folded half turn
    rpao_pkg::rpao_rot_t rot3_next;
    rpao_pkg::rpao_rot_t rot3_reg;

    always_comb
    begin
        rot3_next.x  = sd2_reg.flip ? -x2_reg : x2_reg;
        rot3_next.y  = sd2_reg.flip ? -y2_reg : y2_reg;
        rot3_next.z  = sd2_reg.z;
        rot3_next.ox = sd2_reg.ox;
        rot3_next.oy = sd2_reg.oy;
    end

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            rot3_reg <= rot3_next;
        end
    end

    assign out_data = rot3_reg;

endmodule

@@ design/rpao_cordic_stage.sv @@
// One registered CORDIC micro-rotation with a fixed shift.
module rpao_cordic_stage #(
    parameter int STEP = 0
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  rpao_pkg::rpao_rot_t in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output rpao_pkg::rpao_rot_t out_data
);

    localparam logic signed [rpao_pkg::ZW-1:0] ATAN = rpao_pkg::atan_q40(STEP);

    logic                           vld_reg;
    logic signed [rpao_pkg::XW-1:0] xs;
    logic signed [rpao_pkg::XW-1:0] ys;
    rpao_pkg::rpao_rot_t            rot_next;
    rpao_pkg::rpao_rot_t            rot_reg;

    assign in_ready  = !vld_reg || out_ready;
    assign out_valid = vld_reg;

    assign xs = in_data.x >>> STEP;
    assign ys = in_data.y >>> STEP;

    // rotate toward zero residual angle
    always_comb
    begin
        rot_next = in_data;
        if (!in_data.z[rpao_pkg::ZW-1])
        begin
            rot_next.x = in_data.x - ys;
            rot_next.y = in_data.y + xs;
            rot_next.z = in_data.z - ATAN;
        end
        else
        begin
            rot_next.x = in_data.x + ys;
            rot_next.y = in_data.y - xs;
            rot_next.z = in_data.z + ATAN;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready)
        begin
            rot_reg <= rot_next;
        end
    end

    assign out_data = rot_reg;

endmodule

@@ design/rpao_output.sv @@
// Drop guard bits, add the origin back and clamp to the coordinate range.
module rpao_output (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  rpao_pkg::rpao_rot_t in_data,
    rpao_out_if.source          result
);

    localparam int NST = 2;
    localparam int CW  = rpao_pkg::CW;
    localparam int OW  = rpao_pkg::XW - rpao_pkg::GUARD;
    localparam int SW  = OW + 1;
    localparam logic signed [rpao_pkg::XW-1:0] ORND =
        rpao_pkg::XW'(1) <<< (rpao_pkg::GUARD - 1);
    localparam logic [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};

    function automatic logic [CW:0] clamp_coord(input logic [SW-1:0] v);
        logic          over;
        logic [CW-1:0] val;
        over = (v[SW-1:CW-1] != {(SW-CW+1){v[SW-1]}});
        if (over)
        begin
            val = v[SW-1] ? CMIN : CMAX;
        end
        else
        begin
            val = v[CW-1:0];
        end
        return {over, val};
    endfunction

    logic [NST-1:0] vld_reg;
    logic [NST-1:0] vld_next;
    logic [NST-1:0] vld_src;
    logic [NST:0]   adv;

    always_comb
    begin
        adv[NST] = result.ready;
        for (int s = NST - 1; s >= 0; s--)
        begin
            adv[s] = !vld_reg[s] || adv[s+1];
        end
    end

    assign vld_src  = {vld_reg[NST-2:0], in_valid};
    assign vld_next = (vld_src & adv[NST-1:0]) | (vld_reg & ~adv[NST-1:0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign in_ready = adv[0];

    // stage 1: round half up by the guard bits
    logic signed [rpao_pkg::XW-1:0] xr1;
    logic signed [rpao_pkg::XW-1:0] yr1;
    logic signed [OW-1:0]           x1_reg;
    logic signed [OW-1:0]           y1_reg;
    logic signed [CW-1:0]           ox1_reg;
    logic signed [CW-1:0]           oy1_reg;

    assign xr1 = (in_data.x + ORND) >>> rpao_pkg::GUARD;
    assign yr1 = (in_data.y + ORND) >>> rpao_pkg::GUARD;

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            x1_reg  <= xr1[OW-1:0];
            y1_reg  <= yr1[OW-1:0];
            ox1_reg <= in_data.ox;
            oy1_reg <= in_data.oy;
        end
    end

    // stage 2: add origin, clamp, flag either clamp
    logic signed [SW-1:0] sx2;
    logic signed [SW-1:0] sy2;
    logic [CW:0]          cx2;
    logic [CW:0]          cy2;
    logic [CW-1:0]        rx_reg;
    logic [CW-1:0]        ry_reg;
    logic                 sat_reg;

    assign sx2 = SW'(x1_reg) + SW'(ox1_reg);
    assign sy2 = SW'(y1_reg) + SW'(oy1_reg);
    assign cx2 = clamp_coord(sx2);
    assign cy2 = clamp_coord(sy2);

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            rx_reg  <= cx2[CW-1:0];
            ry_reg  <= cy2[CW-1:0];
            sat_reg <= cx2[CW] | cy2[CW];
        end
    end

    assign result.valid     = vld_reg[NST-1];
    assign result.rotated_x = $signed(rx_reg);
    assign result.rotated_y = $signed(ry_reg);
    assign result.saturated = sat_reg;

endmodule

@@ design/rotate_point_about_origin.sv @@
// Top level of the pipelined point rotator.
//
// Rotates a point about an origin by an angle in degrees, all signed fixed
// point with FRAC_BITS fraction bits. One transaction on the point channel
// carries point_x, point_y, origin_x, origin_y and angle_deg; each one gives
// exactly one transaction on the result channel with rotated_x, rotated_y
// and the saturated flag, in the same order.
//
// Pipeline: CORDIC_STEPS + 12 register stages:
// 7 stages of angle reduction and degree-to-radian scaling, 3 of gain
// compensation, one per CORDIC micro-rotation, 2 for rounding and clamping.
// Throughput: one transaction per cycle while the receiver does not stall,
// set by the one-stage-per-iteration rotator; every stage holds its own
// valid bit.
//
// Reset clears all valid bits; payload registers are not reset. When the
// receiver stalls, the result holds and empty stages keep filling, so point
// ready stays high until every stage holds a transaction. Ready never drops
// while the result register is empty or being taken.
module rotate_point_about_origin #(
    parameter int FRAC_BITS    = rpao_pkg::FRAC_BITS_DEF,
    parameter int CORDIC_STEPS = rpao_pkg::CORDIC_STEPS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    rpao_in_if.sink    point,
    rpao_out_if.source result
);

    // angle stage to prescale
    logic                  ang_valid;
    logic                  ang_ready;
    rpao_pkg::rpao_angle_t ang_data;

    // rotator chain: entry 0 from prescale, entry CORDIC_STEPS to output
    logic                rot_valid [CORDIC_STEPS+1];
    logic                rot_ready [CORDIC_STEPS+1];
    rpao_pkg::rpao_rot_t rot_data  [CORDIC_STEPS+1];

    rpao_angle #(
        .FRAC_BITS (FRAC_BITS)
    ) u_angle (
        .clk       (clk),
        .rst_n     (rst_n),
        .point     (point),
        .out_valid (ang_valid),
        .out_ready (ang_ready),
        .out_data  (ang_data)
    );

    rpao_prescale #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_prescale (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (ang_valid),
        .in_ready  (ang_ready),
        .in_data   (ang_data),
        .out_valid (rot_valid[0]),
        .out_ready (rot_ready[0]),
        .out_data  (rot_data[0])
    );

    // one micro-rotation per stage, shift fixed by position
    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_step
        rpao_cordic_stage #(
            .STEP (i)
        ) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (rot_valid[i]),
            .in_ready  (rot_ready[i]),
            .in_data   (rot_data[i]),
            .out_valid (rot_valid[i+1]),
            .out_ready (rot_ready[i+1]),
            .out_data  (rot_data[i+1])
        );
    end

    rpao_output u_output (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (rot_valid[CORDIC_STEPS]),
        .in_ready (rot_ready[CORDIC_STEPS]),
        .in_data  (rot_data[CORDIC_STEPS]),
        .result   (result)
    );

endmodule

@@ design/rpao_checker.sv @@
// Port-level checker for the point rotator and its bind to the top level.
`include "rotate_point_about_origin_defines.svh"

module rpao_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_ready,
    input logic                           out_valid,
    input logic                           out_ready,
    input logic signed [rpao_pkg::CW-1:0] rotated_x,
    input logic signed [rpao_pkg::CW-1:0] rotated_y,
    input logic                           saturated
);

    localparam logic signed [rpao_pkg::CW-1:0] CMAX = {1'b0, {(rpao_pkg::CW-1){1'b1}}};
    localparam logic signed [rpao_pkg::CW-1:0] CMIN = {1'b1, {(rpao_pkg::CW-1){1'b0}}};

    logic       in_acc;
    logic       out_acc;
    logic [7:0] pend_reg;
    logic [7:0] pend_next;

    assign in_acc    = in_valid && in_ready;
    assign out_acc   = out_valid && out_ready;
    assign pend_next = pend_reg + {7'd0, in_acc} - {7'd0, out_acc};

    // count transactions taken but not yet delivered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    `RPAO_ASSERT_NXT(a_result_holds, clk, rst_n, out_valid && !out_ready, out_valid && $stable(rotated_x) && $stable(rotated_y) && $stable(saturated))
    `RPAO_ASSERT_IMP(a_no_phantom, clk, rst_n, out_valid, pend_reg != 8'd0)
    `RPAO_ASSERT_IMP(a_ready_when_free, clk, rst_n, !out_valid || out_ready, in_ready)
    `RPAO_ASSERT_IMP(a_sat_clamped, clk, rst_n, out_valid && saturated, rotated_x == CMAX || rotated_x == CMIN || rotated_y == CMAX || rotated_y == CMIN)

endmodule

bind rotate_point_about_origin rpao_checker u_rpao_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (point.valid),
    .in_ready  (point.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .rotated_x (result.rotated_x),
    .rotated_y (result.rotated_y),
    .saturated (result.saturated)
);
